@@ sv/itp_pkg.sv @@
`default_nettype none

package itp_pkg;

  // sizing
  localparam int STACK_DEPTH  = 32;
  localparam int NUMBER_WIDTH = 32;
  localparam int CntW         = $clog2(STACK_DEPTH + 1);
  localparam int AddrW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [31:0] NUM_MASK = (NUMBER_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << NUMBER_WIDTH) - 64'd1);

  // token kinds
  localparam logic [2:0] CMD_NUMBER   = 3'd0;
  localparam logic [2:0] CMD_OPERATOR = 3'd1;
  localparam logic [2:0] CMD_LPAREN   = 3'd2;
  localparam logic [2:0] CMD_RPAREN   = 3'd3;
  localparam logic [2:0] CMD_END      = 3'd4;

  // operator codes, stack entry for '(' shares the encoding
  localparam logic [2:0] OP_PLUS     = 3'd0;
  localparam logic [2:0] OP_MINUS    = 3'd1;
  localparam logic [2:0] OP_TIMES    = 3'd2;
  localparam logic [2:0] OP_DIVIDE   = 3'd3;
  localparam logic [2:0] OP_POWER    = 3'd4;
  localparam logic [2:0] LPAREN_CODE = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_NUMBER   = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_STATUS   = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NULL     = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  oper;
    logic [31:0] value;
    logic [1:0]  kind;
  } result_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_PUT,
    EM_PUT_LAST,
    EM_CLOSE
  } em_op_e;

  typedef struct packed {
    em_op_e  op;
    result_t res;
  } em_req_t;

  function automatic logic [1:0] op_rank(logic [2:0] code);
    logic [1:0] r;
    case (code) inside
      OP_PLUS, OP_MINUS:   r = 2'd1;
      OP_TIMES, OP_DIVIDE: r = 2'd2;
      default:             r = 2'd3;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/itp_ram.sv @@
`default_nettype none

module itp_ram #(
  parameter int Width = 3,
  parameter int Depth = 32
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                             wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/itp_emitter.sv @@
`default_nettype none

module itp_emitter
  import itp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire em_req_t req_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      out_res_o,
  output logic         out_last_o
);

  result_t hold_q, hold_d;
  logic    hold_valid_q, hold_valid_d;
  logic    hold_final_q, hold_final_d;
  result_t out_q, out_d;
  logic    out_last_q, out_last_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign ready_o  = !hold_final_q && out_free;

  always_comb begin
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    hold_final_d = hold_final_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (hold_final_q) begin
      // held result closes the run, push it out as soon as there is room
      if (out_free) begin
        out_d        = hold_q;
        out_last_d   = 1'b1;
        out_valid_d  = 1'b1;
        hold_valid_d = 1'b0;
        hold_final_d = 1'b0;
      end
    end else if (out_free) begin
      unique case (req_i.op)
        EM_PUT: begin
          if (hold_valid_q) begin
            out_d       = hold_q;
            out_last_d  = 1'b0;
            out_valid_d = 1'b1;
          end
          hold_d       = req_i.res;
          hold_valid_d = 1'b1;
        end
        EM_PUT_LAST: begin
          if (hold_valid_q) begin
            out_d        = hold_q;
            out_last_d   = 1'b0;
            out_valid_d  = 1'b1;
            hold_d       = req_i.res;
            hold_final_d = 1'b1;
          end else begin
            out_d       = req_i.res;
            out_last_d  = 1'b1;
            out_valid_d = 1'b1;
          end
        end
        EM_CLOSE: begin
          if (hold_valid_q) begin
            out_d        = hold_q;
            out_last_d   = 1'b1;
            out_valid_d  = 1'b1;
            hold_valid_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      hold_final_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      hold_final_q <= hold_final_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

@@ sv/itp_seq.sv @@
`default_nettype none

module itp_seq
  import itp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        cmd_i,
  input  wire logic [31:0]       value_i,
  input  wire logic [2:0]        opc_i,
  input  wire logic              em_ready_i,
  output em_req_t                em_req_o,
  output logic                   ram_we_o,
  output logic      [AddrW-1:0]  ram_waddr_o,
  output logic      [2:0]        ram_wdata_o,
  output logic      [AddrW-1:0]  ram_raddr_o,
  input  wire logic [2:0]        ram_rdata_i
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic            state_q, state_d;
  logic [2:0]      cmd_q;
  logic [31:0]     val_q;
  logic [2:0]      opc_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            seen_q, seen_d;
  logic            drop_q, drop_d;
  logic [CntW-1:0] rd_ptr;
  logic            has, full, top_lp, pop_ok, stall;
  logic            we;
  logic [2:0]      wdata;
  em_req_t         req;

  assign has    = (cnt_q != '0);
  assign full   = (cnt_q == CntW'(STACK_DEPTH));
  assign top_lp = (ram_rdata_i == LPAREN_CODE);
  assign pop_ok = has && !top_lp && (op_rank(ram_rdata_i) >= op_rank(opc_q));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    seen_d  = seen_q;
    drop_d  = drop_q;
    we      = 1'b0;
    wdata   = opc_q;
    req     = '{op: EM_NONE, res: '0};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_WORK;
          if (cmd_i != CMD_END) begin
            seen_d = 1'b1;
          end
        end
      end
      S_WORK: begin
        state_d = S_IDLE;
        if (cmd_q == CMD_END) begin
          if (drop_q) begin
            cnt_d  = '0;
            seen_d = 1'b0;
            drop_d = 1'b0;
          end else if (!seen_q) begin
            req.op         = EM_PUT_LAST;
            req.res.kind   = KIND_STATUS;
            req.res.status = ST_NULL;
            cnt_d  = '0;
            seen_d = 1'b0;
          end else if (has && !top_lp) begin
            // flush one operator a cycle while the emitter does not stall
            req.op       = EM_PUT;
            req.res.kind = KIND_OPERATOR;
            req.res.oper = ram_rdata_i;
            cnt_d   = cnt_q - CntW'(1);
            state_d = S_WORK;
          end else begin
            req.op         = EM_PUT_LAST;
            req.res.kind   = KIND_STATUS;
            req.res.status = has ? ST_MISMATCH : ST_OK;
            cnt_d  = '0;
            seen_d = 1'b0;
          end
        end else if (!drop_q) begin
          unique case (cmd_q)
            CMD_NUMBER: begin
              req.op        = EM_PUT_LAST;
              req.res.kind  = KIND_NUMBER;
              req.res.value = val_q & NUM_MASK;
            end
            CMD_OPERATOR: begin
              if (opc_q > OP_POWER) begin
                req.op         = EM_PUT_LAST;
                req.res.kind   = KIND_STATUS;
                req.res.status = ST_INVALID;
                cnt_d  = '0;
                drop_d = 1'b1;
              end else if (pop_ok) begin
                req.op       = EM_PUT;
                req.res.kind = KIND_OPERATOR;
                req.res.oper = ram_rdata_i;
                cnt_d   = cnt_q - CntW'(1);
                state_d = S_WORK;
              end else if (full) begin
                req.op         = EM_PUT_LAST;
                req.res.kind   = KIND_STATUS;
                req.res.status = ST_OVERFLOW;
                cnt_d  = '0;
                drop_d = 1'b1;
              end else begin
                req.op = EM_CLOSE;
                we     = 1'b1;
                cnt_d  = cnt_q + CntW'(1);
              end
            end
            CMD_LPAREN: begin
              if (full) begin
                req.op         = EM_PUT_LAST;
                req.res.kind   = KIND_STATUS;
                req.res.status = ST_OVERFLOW;
                cnt_d  = '0;
                drop_d = 1'b1;
              end else begin
                wdata = LPAREN_CODE;
                we    = 1'b1;
                cnt_d = cnt_q + CntW'(1);
              end
            end
            CMD_RPAREN: begin
              if (has && !top_lp) begin
                req.op       = EM_PUT;
                req.res.kind = KIND_OPERATOR;
                req.res.oper = ram_rdata_i;
                cnt_d   = cnt_q - CntW'(1);
                state_d = S_WORK;
              end else if (has) begin
                req.op = EM_CLOSE;
                cnt_d  = cnt_q - CntW'(1);
              end else begin
                req.op         = EM_PUT_LAST;
                req.res.kind   = KIND_STATUS;
                req.res.status = ST_MISMATCH;
                drop_d = 1'b1;
              end
            end
            default: begin
              req.op         = EM_PUT_LAST;
              req.res.kind   = KIND_STATUS;
              req.res.status = ST_INVALID;
              cnt_d  = '0;
              drop_d = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // hold everything while the emitter cannot take the request
    stall = (state_q == S_WORK) && (req.op != EM_NONE) && !em_ready_i;
    if (stall) begin
      state_d = state_q;
      cnt_d   = cnt_q;
      seen_d  = seen_q;
      drop_d  = drop_q;
      we      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      seen_q  <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      seen_q  <= seen_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      cmd_q <= cmd_i;
      val_q <= value_i;
      opc_q <= opc_i;
    end
  end

  // read the entry that will be on top next cycle
  assign rd_ptr      = cnt_d - CntW'(1);
  assign ram_raddr_o = rd_ptr[AddrW-1:0];
  assign ram_waddr_o = cnt_q[AddrW-1:0];
  assign ram_we_o    = we;
  assign ram_wdata_o = wdata;
  assign em_req_o    = req;
  assign in_ready_o  = (state_q == S_IDLE);

endmodule

`default_nettype wire

@@ sv/infix_to_postfix_converter.sv @@
// Shunting-yard infix to postfix converter. Tokens arrive one request at a
// time on the slave stream; numbers pass straight through, operators are
// held on an operator stack and leave in postfix order, with equal or higher
// precedence popped first (so '^' behaves left-associatively). Every result
// caused by one token leaves on the master stream, the final one flagged by
// tlast; the end token flushes the stack and closes with a status result.
// After an error the block drops tokens until the next end token, which
// itself gives no result. The sequencer takes one token at a time and pops
// operators at one stack entry a cycle, reading them from the stack memory;
// while a result waits unaccepted in the output register, any sequencer step
// that hands over a result is held, and a closing result parked in the hold
// stage holds every sequencer step that hands over a request until it has
// moved into the output register.
// The stack memory needs no clearing pass: only entries below the fill count
// are ever used.
`default_nettype none

module infix_to_postfix_converter
  import itp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input token stream
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [39:0] s_tdata_i,  // cmd[2:0], number_value[34:3], operator_code[37:35]
  // result stream
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic      [39:0] m_tdata_o,  // item_kind[1:0], out_value[33:2],
                                       // out_operator[36:34], status_code[39:37]
  output logic             m_tlast_o   // last_of_run
);

  // sequencer to emitter request
  em_req_t            em_req;
  logic               em_ready;

  // stack memory port
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [2:0]         ram_wdata;
  logic [AddrW-1:0]   ram_raddr;
  logic [2:0]         ram_rdata;

  result_t            out_res;

  // token sequencer, owns the stack pointer and error flags
  itp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .cmd_i       (s_tdata_i[2:0]),
    .value_i     (s_tdata_i[34:3]),
    .opc_i       (s_tdata_i[37:35]),
    .em_ready_i  (em_ready),
    .em_req_o    (em_req),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // operator stack, registered read of the next top entry
  itp_ram #(
    .Width (3),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // holds one result back so tlast can be set once the run is known to end
  itp_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (em_req),
    .ready_o     (em_ready),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_res_o   (out_res),
    .out_last_o  (m_tlast_o)
  );

  // pack result fields, kind in the lowest bits
  assign m_tdata_o = {out_res.status, out_res.oper, out_res.value, out_res.kind};

endmodule

`default_nettype wire

@@ sv/itp_checker.sv @@
`default_nettype none

module itp_checker
  import itp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_tvalid_i,
  input wire logic        s_tready_o,
  input wire logic        m_tvalid_o,
  input wire logic        m_tready_i,
  input wire logic [39:0] m_tdata_o,
  input wire logic        m_tlast_o
);

  // stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result request dropped while stalled");

  // stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o) && $stable(m_tlast_o))
    else $error("result payload changed while stalled");

  // the token stream is not ready in the cycle after a token is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("token taken in back-to-back cycles");

  // status results always close a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tdata_o[1:0] == KIND_STATUS) |-> m_tlast_o)
    else $error("status result without tlast");

  // only number results carry a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tdata_o[1:0] != KIND_NUMBER) |-> (m_tdata_o[33:2] == 32'd0))
    else $error("non-number result carries a value");

endmodule

bind infix_to_postfix_converter itp_checker u_checker (.*);

`default_nettype wire

@@ verif/infix_to_postfix_converter_test.sv @@
`default_nettype none

// token stream in, postfix stream out: a behavioural shunting-yard model runs
// alongside the dut and every result is checked in order against it, or against the row for typed directed rows

module infix_to_postfix_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  // token kinds and operator codes the package leaves unnamed
  localparam logic [2:0] CMD_INVALID = 3'd5;
  localparam logic [2:0] OPC_BAD     = 3'd7;
  // operator field of number and status results
  localparam logic [2:0] OPER_NONE   = 3'd0;

  localparam int RANDOM_ITEMS = 300;
  localparam int SETTLE_CYC   = 40;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [2:0]  opc;
  } token_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [2:0]  oper;
    logic [2:0]  status;
    logic        last;
  } postfix_item_t;

  // directed row: the token, and where obvious the single result it gives
  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [2:0]  opc;
    logic        typed;
    logic [1:0]  kind;
    logic [31:0] xvalue;
    logic [2:0]  xoper;
    logic [2:0]  xstatus;
  } dir_row_t;

  localparam dir_row_t DIRECTED [25] = '{
    // end straight after reset: null expression
    '{CMD_END,      32'd0,        OP_PLUS,   1'b1, KIND_STATUS, 32'd0,        OPER_NONE, ST_NULL},
    // number extremes, stray operator bits ignored
    '{CMD_NUMBER,   32'd0,        OP_PLUS,   1'b1, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    '{CMD_NUMBER,   32'hFFFF_FFFF, OPC_BAD,  1'b1, KIND_NUMBER, 32'hFFFF_FFFF, OPER_NONE, ST_OK},
    '{CMD_OPERATOR, 32'hFFFF_FFFF, OP_PLUS,  1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    '{CMD_NUMBER,   32'd5,        OP_PLUS,   1'b1, KIND_NUMBER, 32'd5,        OPER_NONE, ST_OK},
    '{CMD_OPERATOR, 32'd0,        OP_TIMES,  1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    '{CMD_NUMBER,   32'd3,        OP_PLUS,   1'b1, KIND_NUMBER, 32'd3,        OPER_NONE, ST_OK},
    // minus pops times and plus
    '{CMD_OPERATOR, 32'd0,        OP_MINUS,  1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    // power then power: left-associative pop
    '{CMD_OPERATOR, 32'd0,        OP_POWER,  1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    '{CMD_OPERATOR, 32'd0,        OP_POWER,  1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    '{CMD_OPERATOR, 32'd0,        OP_DIVIDE, 1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    // pops stop at an open paren
    '{CMD_LPAREN,   32'd0,        OP_PLUS,   1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    '{CMD_NUMBER,   32'd7,        OP_PLUS,   1'b1, KIND_NUMBER, 32'd7,        OPER_NONE, ST_OK},
    '{CMD_OPERATOR, 32'd0,        OP_PLUS,   1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    '{CMD_RPAREN,   32'd0,        OP_PLUS,   1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    '{CMD_END,      32'd0,        OP_PLUS,   1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    // close paren with nothing open, then the silent end
    '{CMD_RPAREN,   32'd0,        OP_PLUS,   1'b1, KIND_STATUS, 32'd0,        OPER_NONE, ST_MISMATCH},
    '{CMD_END,      32'd0,        OP_PLUS,   1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    // open paren still on the stack at end
    '{CMD_LPAREN,   32'd0,        OP_PLUS,   1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    '{CMD_OPERATOR, 32'd0,        OP_DIVIDE, 1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    '{CMD_END,      32'd0,        OP_PLUS,   1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    // bad operator code and bad token kind
    '{CMD_OPERATOR, 32'd0,        OPC_BAD,   1'b1, KIND_STATUS, 32'd0,        OPER_NONE, ST_INVALID},
    '{CMD_END,      32'd0,        OP_PLUS,   1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK},
    '{CMD_INVALID,  32'd0,        OP_PLUS,   1'b1, KIND_STATUS, 32'd0,        OPER_NONE, ST_INVALID},
    '{CMD_END,      32'd0,        OP_PLUS,   1'b0, KIND_NUMBER, 32'd0,        OPER_NONE, ST_OK}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [39:0] s_tdata_i;  // cmd[2:0], number_value[34:3], operator_code[37:35]
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [39:0] m_tdata_o;  // item_kind[1:0], out_value[33:2],
                           // out_operator[36:34], status_code[39:37]
  logic        m_tlast_o;  // last_of_run

  infix_to_postfix_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  // shadow of the operator stack and expression flags
  logic [2:0]    held_ops [STACK_DEPTH];
  int            held_cnt;
  bit            expr_open;
  bit            skipping;

  postfix_item_t step_out[$];           // results of the token in hand
  postfix_item_t postfix_expected[$];   // results still owed by the dut

  int            mismatches;
  int            sent_items;
  int            results_seen;
  bit            tx_calm;
  bit            rx_calm;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t ns: %s", $time, what);
  endtask

  function automatic int prec(logic [2:0] code);
    case (code)
      OP_PLUS, OP_MINUS:   return 1;
      OP_TIMES, OP_DIVIDE: return 2;
      default:             return 3;
    endcase
  endfunction

  function automatic void emit(logic [1:0] kind, logic [31:0] value, logic [2:0] oper,
                               logic [2:0] status);
    postfix_item_t r;
    r.kind   = kind;
    r.value  = value;
    r.oper   = oper;
    r.status = status;
    r.last   = 1'b0;
    step_out.push_back(r);
  endfunction

  // error: report, empty the stack and drop tokens until end
  function automatic void abort_expr(logic [2:0] status);
    emit(KIND_STATUS, 32'd0, OPER_NONE, status);
    held_cnt = 0;
    skipping = 1'b1;
  endfunction

  function automatic void push_op(logic [2:0] code);
    if (held_cnt >= STACK_DEPTH) begin
      abort_expr(ST_OVERFLOW);
    end else begin
      held_ops[held_cnt] = code;
      held_cnt++;
    end
  endfunction

  // pop and send operators down to the nearest open paren, which is consumed
  function automatic bit unwind_to_paren();
    logic [2:0] top;
    while (held_cnt > 0) begin
      held_cnt--;
      top = held_ops[held_cnt];
      if (top == LPAREN_CODE) return 1'b1;
      emit(KIND_OPERATOR, 32'd0, top, ST_OK);
    end
    return 1'b0;
  endfunction

  // one token through the shunting-yard, results left in step_out
  function automatic void shunt_token(token_t t);
    postfix_item_t r;
    bit            paren_left;
    step_out.delete();
    if (t.cmd == CMD_END) begin
      if (!skipping) begin
        if (!expr_open) begin
          emit(KIND_STATUS, 32'd0, OPER_NONE, ST_NULL);
        end else begin
          paren_left = unwind_to_paren();
          emit(KIND_STATUS, 32'd0, OPER_NONE, paren_left ? ST_MISMATCH : ST_OK);
        end
      end
      held_cnt  = 0;
      expr_open = 1'b0;
      skipping  = 1'b0;
    end else begin
      expr_open = 1'b1;
      if (!skipping) begin
        case (t.cmd)
          CMD_NUMBER: begin
            emit(KIND_NUMBER, t.value & NUM_MASK, OPER_NONE, ST_OK);
          end
          CMD_OPERATOR: begin
            if (t.opc > OP_POWER) begin
              abort_expr(ST_INVALID);
            end else begin
              while (held_cnt > 0 && held_ops[held_cnt-1] != LPAREN_CODE &&
                     prec(held_ops[held_cnt-1]) >= prec(t.opc)) begin
                emit(KIND_OPERATOR, 32'd0, held_ops[held_cnt-1], ST_OK);
                held_cnt--;
              end
              push_op(t.opc);
            end
          end
          CMD_LPAREN: begin
            push_op(LPAREN_CODE);
          end
          CMD_RPAREN: begin
            if (!unwind_to_paren()) abort_expr(ST_MISMATCH);
          end
          default: begin
            abort_expr(ST_INVALID);
          end
        endcase
      end
    end
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
  endfunction

  // token with the fields it does not use filled with noise
  function automatic token_t tok(logic [2:0] cmd, logic [31:0] value, logic [2:0] opc);
    token_t t;
    t.cmd   = cmd;
    t.value = (cmd == CMD_NUMBER) ? value : $urandom;
    t.opc   = (cmd == CMD_OPERATOR) ? opc : 3'($urandom_range(0, 7));
    return t;
  endfunction

  function automatic logic [31:0] num_val();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // one request on the token stream; valid stays up when no gap follows
  task automatic send_token(input token_t t, input bit use_typed = 1'b0,
                            input postfix_item_t typed_res = '0);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {2'b00, t.opc, t.value, t.cmd};
    do @(posedge clk_i); while (!s_tready_o);
    // results cannot leave before the next edge, so queue them now
    sent_items++;
    shunt_token(t);
    if (use_typed) begin
      postfix_expected.push_back(typed_res);
    end else begin
      foreach (step_out[i]) postfix_expected.push_back(step_out[i]);
    end
  endtask

  // hold the token stream until every owed result has come out
  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (postfix_expected.size() != 0);
  endtask

  // random well-formed expression, optionally with one junk token spliced in
  task automatic run_expression(input int max_len, input bit corrupt);
    int depth;
    int len;
    int junk_at;
    bit want_operand;
    bit done;
    depth        = 0;
    len          = 0;
    want_operand = 1'b1;
    done         = 1'b0;
    junk_at      = corrupt ? int'($urandom_range(0, max_len)) : -1;
    while (!done) begin
      if (len == junk_at) begin
        send_token(tok(3'($urandom_range(0, 7)), num_val(), 3'($urandom_range(0, 7))));
        junk_at = -1;
      end
      if (want_operand) begin
        if (depth < 5 && $urandom_range(0, 3) == 0) begin
          send_token(tok(CMD_LPAREN, 32'd0, OP_PLUS));
          depth++;
        end else begin
          send_token(tok(CMD_NUMBER, num_val(), OP_PLUS));
          want_operand = 1'b0;
          len++;
        end
      end else if (depth > 0 && ($urandom_range(0, 2) == 0 || len >= max_len)) begin
        send_token(tok(CMD_RPAREN, 32'd0, OP_PLUS));
        depth--;
      end else if (len >= max_len) begin
        done = 1'b1;
      end else begin
        send_token(tok(CMD_OPERATOR, 32'd0, 3'($urandom_range(0, 4))));
        want_operand = 1'b1;
      end
    end
    send_token(tok(CMD_END, 32'd0, OP_PLUS));
  endtask

  // deep nesting around the stack limit, overflowing now and then
  task automatic nest_deep();
    int levels;
    levels = $urandom_range(29, 34);
    wait_drained();
    for (int i = 0; i < levels; i++) begin
      send_token(tok(CMD_LPAREN, 32'd0, OP_PLUS));
      if ($urandom_range(0, 4) == 0) begin
        send_token(tok(CMD_NUMBER, num_val(), OP_PLUS));
        send_token(tok(CMD_OPERATOR, 32'd0, 3'($urandom_range(0, 4))));
      end
    end
    send_token(tok(CMD_NUMBER, num_val(), OP_PLUS));
    for (int i = 0; i < levels; i++) send_token(tok(CMD_RPAREN, 32'd0, OP_PLUS));
    send_token(tok(CMD_END, 32'd0, OP_PLUS));
  endtask

  // result side: random back-pressure, in-order field compare
  initial begin : result_sink
    postfix_item_t want;
    postfix_item_t got;
    int            stall;
    m_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 24) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      got.kind   = m_tdata_o[1:0];
      got.value  = m_tdata_o[33:2];
      got.oper   = m_tdata_o[36:34];
      got.status = m_tdata_o[39:37];
      got.last   = m_tlast_o;
      results_seen++;
      if (postfix_expected.size() == 0) begin
        flag_mismatch($sformatf("result %0d not expected: kind %0d value %h oper %0d status %0d",
                                results_seen, got.kind, got.value, got.oper, got.status));
      end else begin
        want = postfix_expected.pop_front();
        if (got.kind != want.kind)
          flag_mismatch($sformatf("result %0d item_kind %0d, expected %0d",
                                  results_seen, got.kind, want.kind));
        if (got.value != want.value)
          flag_mismatch($sformatf("result %0d out_value %h, expected %h",
                                  results_seen, got.value, want.value));
        if (got.oper != want.oper)
          flag_mismatch($sformatf("result %0d out_operator %0d, expected %0d",
                                  results_seen, got.oper, want.oper));
        if (got.status != want.status)
          flag_mismatch($sformatf("result %0d status_code %0d, expected %0d",
                                  results_seen, got.status, want.status));
        if (got.last != want.last)
          flag_mismatch($sformatf("result %0d tlast %0d, expected %0d",
                                  results_seen, got.last, want.last));
      end
    end
  end

  initial begin : token_source
    token_t        t;
    postfix_item_t r;
    int            pick;
    rst_ni       = 1'b0;
    s_tvalid_i   = 1'b0;
    s_tdata_i    = '0;
    held_cnt     = 0;
    expr_open    = 1'b0;
    skipping     = 1'b0;
    mismatches   = 0;
    sent_items   = 0;
    results_seen = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk
    foreach (DIRECTED[i]) begin
      t.cmd   = DIRECTED[i].cmd;
      t.value = DIRECTED[i].value;
      t.opc   = DIRECTED[i].opc;
      if (DIRECTED[i].typed) begin
        r.kind   = DIRECTED[i].kind;
        r.value  = DIRECTED[i].xvalue;
        r.oper   = DIRECTED[i].xoper;
        r.status = DIRECTED[i].xstatus;
        r.last   = 1'b1;
        send_token(t, 1'b1, r);
      end else begin
        send_token(t);
      end
    end

    // random part, opened with a full pause and one deep nest
    wait_drained();
    sent_items = 0;
    nest_deep();
    while (sent_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) tx_calm = !tx_calm;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_expression($urandom_range(1, 8), 1'b0);
      end else if (pick < 82) begin
        run_expression($urandom_range(1, 8), 1'b1);
      end else if (pick < 90) begin
        // raw noise, any kind and operator code
        repeat ($urandom_range(1, 6))
          send_token(tok(3'($urandom_range(0, 7)), num_val(), 3'($urandom_range(0, 7))));
        send_token(tok(CMD_END, 32'd0, OP_PLUS));
      end else if (pick < 94) begin
        nest_deep();
      end else begin
        // bare end: null expression
        send_token(tok(CMD_END, 32'd0, OP_PLUS));
      end
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
